// File: rtl/assert_macros.svh
// assertion macros for the detector unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/nrdd_pkg.sv
// package for the node reservation deadlock detector
// constants and decision codes, no dependencies
package nrdd_pkg;
	localparam int NumAgents = 16;
	localparam int NumNodes  = 256;
	localparam int PrioBits  = 16;

	localparam logic [1:0] DEC_GRANT    = 2'd0;
	localparam logic [1:0] DEC_WAIT     = 2'd1;
	localparam logic [1:0] DEC_DEADLOCK = 2'd2;
	localparam logic [1:0] DEC_RELEASED = 2'd3;

	localparam logic ACT_MOVE    = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef logic [1:0] decision_t;
endpackage

// File: rtl/node_reservation_deadlock_detector_unit.sv
// Usage: a transaction enters on start while busy is low and carries action,
// agent_id, from_node, to_node and agent_priority. One decision comes back on
// the decision port, marked by done for exactly one cycle.
// A release, a grant or a plain wait goes through the read, decision and output
// states before done. A blocked move then walks the wait-for chain one agent a
// cycle; a loop back to the requester adds a second walk over the loop members
// that picks the yielder.
// A new transaction can be accepted at the same edge that accepts done.
// The owner table is a synchronous memory with a registered read; the
// wait-for edges and priorities sit in per-agent registers.
// After reset a clearing pass sweeps the owner table one entry a cycle;
// busy stays high during it.
// The receiver cannot stall: done is a single-cycle strobe.
// Agent ids wrap modulo NUM_AGENTS, node numbers modulo NUM_NODES.
`include "assert_macros.svh"
module node_reservation_deadlock_detector_unit
	import nrdd_pkg::*;
#(
	parameter int NUM_AGENTS = NumAgents,
	parameter int NUM_NODES  = NumNodes,
	parameter int PRIO_BITS  = PrioBits
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [3:0]        agent_id,
	input  logic [7:0]        from_node,
	input  logic [7:0]        to_node,
	input  logic signed [15:0] agent_priority,
	output logic              done,
	output logic [1:0]        decision
);
	localparam int AW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
	localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int PW = (PRIO_BITS < 16) ? PRIO_BITS : 16;
	localparam int CW = AW + 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_DEC   = 4'd3;
	localparam logic [3:0] ST_WALK  = 4'd4;
	localparam logic [3:0] ST_PICK  = 4'd5;
	localparam logic [3:0] ST_OUT   = 4'd6;

	// owner memory entry: valid + id
	logic [AW:0] owner_mem [NUM_NODES];
	logic [AW:0] owner_rd_q;
	logic        mem_we;
	logic [NW-1:0] mem_wa;
	logic [AW:0]   mem_wd;

	logic [3:0] state_q;
	logic [NW:0] clr_q;

	logic            act_q;
	logic [AW-1:0]   agent_q;
	logic [NW-1:0]   to_q;
	logic            same_q;
	decision_t       dec_q;

	logic [NUM_AGENTS-1:0] wvalid_q;
	logic [AW-1:0]   wwho_q [NUM_AGENTS];
	logic [PW-1:0]   prio_q [NUM_AGENTS];

	logic [NUM_AGENTS-1:0] seen_q;
	logic [AW-1:0]   cur_q;
	logic [AW-1:0]   best_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   len_q;

	logic [AW-1:0] agent_in;
	logic [NW-1:0] to_in;
	logic [AW-1:0] nxt;
	logic          own_free;
	logic          own_mine;
	logic          better;

	// agent id wrap as a small constant table
	function automatic logic [AW-1:0] wrap_agent(input logic [3:0] v);
		logic [AW-1:0] r;
		r = '0;
		for (int i = 0; i < 16; i++)
			if (v == 4'(i))
				r = AW'(i % NUM_AGENTS);
		return r;
	endfunction

	// node number wrap as a constant table
	function automatic logic [NW-1:0] wrap_node(input logic [7:0] v);
		logic [NW-1:0] r;
		r = '0;
		for (int i = 0; i < 256; i++)
			if (v == 8'(i))
				r = NW'(i % NUM_NODES);
		return r;
	endfunction

	// wrap ids and nodes
	always_comb begin
		agent_in = wrap_agent(agent_id);
		to_in    = wrap_node(to_node);
	end

	assign busy     = (state_q != ST_IDLE);
	assign own_free = !owner_rd_q[AW];
	assign own_mine = owner_rd_q[AW-1:0] == agent_q;
	assign nxt      = wwho_q[cur_q];
	assign better   = (prio_q[cur_q] < prio_q[best_q]) ||
		((prio_q[cur_q] == prio_q[best_q]) && (cur_q > best_q));

	// owner memory write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = to_q;
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q[NW-1:0];
		end else if (state_q == ST_DEC) begin
			if (act_q == ACT_RELEASE) begin
				mem_we = !own_free && own_mine;
			end else if (own_free || own_mine) begin
				mem_we = 1'b1;
				mem_wd = {1'b1, agent_q};
			end
		end
	end

	// owner memory
	always_ff @(posedge clk) begin
		if (mem_we)
			owner_mem[mem_wa] <= mem_wd;
		owner_rd_q <= owner_mem[to_q];
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			wvalid_q <= '0;
			done     <= 1'b0;
			act_q    <= ACT_MOVE;
			agent_q  <= '0;
			to_q     <= '0;
			same_q   <= 1'b0;
			dec_q    <= DEC_GRANT;
			seen_q   <= '0;
			cur_q    <= '0;
			best_q   <= '0;
			cnt_q    <= '0;
			len_q    <= '0;
			for (int i = 0; i < NUM_AGENTS; i++) begin
				prio_q[i] <= {1'b1, {(PW-1){1'b0}}};
				wwho_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (NW+1)'(NUM_NODES - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						act_q   <= action;
						agent_q <= agent_in;
						to_q    <= to_in;
						same_q  <= (from_node == to_node);
						if (action == ACT_MOVE)
							prio_q[agent_in] <= agent_priority[PW-1:0] ^ {1'b1, {(PW-1){1'b0}}};
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_DEC;
				ST_DEC: begin
					state_q <= ST_OUT;
					if (act_q == ACT_RELEASE) begin
						wvalid_q[agent_q] <= 1'b0;
						dec_q <= DEC_RELEASED;
					end else if (own_free || own_mine) begin
						wvalid_q[agent_q] <= 1'b0;
						dec_q <= DEC_GRANT;
					end else begin
						dec_q <= DEC_WAIT;
						if (!same_q) begin
							wvalid_q[agent_q] <= 1'b1;
							wwho_q[agent_q]   <= owner_rd_q[AW-1:0];
							cur_q   <= agent_q;
							seen_q  <= '0;
							cnt_q   <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				// follow edges one agent a cycle
				ST_WALK: begin
					if (cnt_q != CW'(NUM_AGENTS))
						cnt_q <= cnt_q + 1'b1;
					if (!wvalid_q[cur_q] || seen_q[nxt]) begin
						state_q <= ST_OUT;
					end else if (nxt == agent_q) begin
						len_q   <= (cnt_q != CW'(NUM_AGENTS)) ? cnt_q + 1'b1 : cnt_q;
						cnt_q   <= '0;
						cur_q   <= agent_q;
						best_q  <= agent_q;
						state_q <= ST_PICK;
					end else begin
						seen_q[nxt] <= 1'b1;
						cur_q <= nxt;
					end
				end
				// second walk over the loop members for the yielder
				ST_PICK: begin
					if (cnt_q == len_q) begin
						if (best_q == agent_q) begin
							wvalid_q[agent_q] <= 1'b0;
							dec_q <= DEC_DEADLOCK;
						end
						state_q <= ST_OUT;
					end else begin
						if (better)
							best_q <= cur_q;
						cur_q <= nxt;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign decision = dec_q;

	`ASSERT_NEXT(a_done_from_out, clk, arst_n, state_q == ST_OUT, done)
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done, state_q == ST_IDLE)
	`ASSERT_IMPL(a_pick_len, clk, arst_n, state_q == ST_PICK, cnt_q <= len_q)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
endmodule
